[rtl/core/plcm_pkg.sv]
// Package for the piecewise-linear color map.
// Holds the breakpoint entry type, command and status codes, and the divider port types.
// No dependencies.
package plcm_pkg;

	localparam int CHANNELS   = 3;
	localparam int VALUE_W    = 16;
	localparam int CHAN_W     = 8;
	localparam int CHAN_IDX_W = 2;
	localparam int OFF_W      = 16;
	localparam int PROD_W     = CHAN_W + OFF_W;
	localparam int DIVIDEND_W = PROD_W + 2;
	localparam int DIVISOR_W  = OFF_W + 1;
	localparam int QUOT_W     = CHAN_W;
	localparam int STEP_W     = 3;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [CHANNELS-1:0][CHAN_W-1:0] color_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		color_t                    color;
	} bp_entry_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

[rtl/core/plcm_in_if.sv]
// Input channel of the color map: one command word per handshake.
// Depends on nothing.
interface plcm_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] value;
	logic [7:0]         red_in;
	logic [7:0]         green_in;
	logic [7:0]         blue_in;

	modport source (output valid, command, value, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, command, value, red_in, green_in, blue_in, output ready);
endinterface

[rtl/core/plcm_out_if.sv]
// Output channel of the color map: one result word per handshake.
// Depends on nothing.
interface plcm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [1:0] status;

	modport source (output valid, red_out, green_out, blue_out, status, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

[rtl/core/piecewise_linear_color_map.sv]
// Piecewise-linear color map. One word in process; ready is high only when idle.
// Add: an empty or full table goes straight to the output, else entries shift up one by one.
// Lookup: an empty table goes straight to the output, else it clamps at the end entries or
// scans one entry at a time, then interpolates 3 channels in turn with the 8-step divider.
// The result then waits in an output register; the next word is taken meanwhile.
// Reset clears the point count and control; the table holds garbage until written.
module piecewise_linear_color_map #(
	parameter int MAX_POINTS = 16
) (
	input logic         clk,
	input logic         arst_n,
	plcm_in_if.sink     req,
	plcm_out_if.source  rsp
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_CMP,
		S_ADD_PUT,
		S_LK_FIRST,
		S_LK_LAST,
		S_LK_SCAN,
		S_IP_MUL,
		S_IP_DIV,
		S_FINISH
	} state_t;

	state_t                                  state_q;
	logic [CW-1:0]                           cnt_q;
	logic [IW-1:0]                           k_q;
	logic signed [plcm_pkg::VALUE_W-1:0]     val_q;
	plcm_pkg::color_t                        cin_q;
	plcm_pkg::bp_entry_t                     prev_q;
	plcm_pkg::bp_entry_t                     next_q;
	logic [plcm_pkg::OFF_W-1:0]              off_q;
	logic [plcm_pkg::OFF_W-1:0]              span_q;
	logic [plcm_pkg::CHAN_IDX_W-1:0]         ch_q;
	logic                                    neg_q;
	plcm_pkg::color_t                        color_q;
	logic [1:0]                              status_q;
	logic                                    out_valid_q;
	plcm_pkg::color_t                        out_color_q;
	logic [1:0]                              out_status_q;

	logic                                    accept;
	logic [CW-1:0]                           cnt_m1;
	logic [IW-1:0]                           last_idx;
	logic                                    full;
	logic                                    empty;
	logic                                    mem_rd_en;
	logic [IW-1:0]                           mem_rd_addr;
	plcm_pkg::bp_entry_t                     mem_rd_data;
	logic                                    mem_wr_en;
	logic [IW-1:0]                           mem_wr_addr;
	plcm_pkg::bp_entry_t                     mem_wr_data;
	plcm_pkg::bp_entry_t                     new_entry;
	plcm_pkg::bp_entry_t                     req_entry;
	plcm_pkg::div_req_t                      div_req;
	plcm_pkg::div_rsp_t                      div_rsp;
	logic                                    rd_gt_val;
	logic                                    val_le_rd;
	logic                                    val_ge_rd;
	logic                                    val_lt_rd;
	logic signed [plcm_pkg::VALUE_W:0]       off_w;
	logic signed [plcm_pkg::VALUE_W:0]       span_w;
	logic [plcm_pkg::CHAN_W-1:0]             c0;
	logic [plcm_pkg::CHAN_W-1:0]             c1;
	logic                                    neg_w;
	logic [plcm_pkg::CHAN_W-1:0]             mag_w;
	logic [plcm_pkg::PROD_W-1:0]             prod_w;
	logic [plcm_pkg::CHAN_W-1:0]             chan_res;

	assign accept   = req.valid && req.ready;
	assign cnt_m1   = cnt_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign full     = (cnt_q == CW'(MAX_POINTS));
	assign empty    = (cnt_q == '0);

	assign req_entry.value    = req.value;
	assign req_entry.color[0] = req.red_in;
	assign req_entry.color[1] = req.green_in;
	assign req_entry.color[2] = req.blue_in;
	assign new_entry.value    = val_q;
	assign new_entry.color    = cin_q;

	// Compare the word just read against the held value
	assign rd_gt_val = ($signed(mem_rd_data.value) > val_q);
	assign val_le_rd = (val_q <= $signed(mem_rd_data.value));
	assign val_ge_rd = (val_q >= $signed(mem_rd_data.value));
	assign val_lt_rd = (val_q < $signed(mem_rd_data.value));

	// Segment offset and span against the lower breakpoint
	assign off_w  = {val_q[plcm_pkg::VALUE_W-1], val_q}
		- {prev_q.value[plcm_pkg::VALUE_W-1], prev_q.value};
	assign span_w = {mem_rd_data.value[plcm_pkg::VALUE_W-1], mem_rd_data.value}
		- {prev_q.value[plcm_pkg::VALUE_W-1], prev_q.value};

	// Shared channel arithmetic: |c1-c0| * offset, then c0 +/- quotient
	assign c0     = prev_q.color[ch_q];
	assign c1     = next_q.color[ch_q];
	assign neg_w  = (c1 < c0);
	assign mag_w  = neg_w ? (c0 - c1) : (c1 - c0);
	assign prod_w = {{plcm_pkg::OFF_W{1'b0}}, mag_w} * {{plcm_pkg::CHAN_W{1'b0}}, off_q};
	assign chan_res = neg_q ? (c0 - div_rsp.quot) : (c0 + div_rsp.quot);

	// Drive the table ports and the divider request from the sequencer state
	always_comb begin
		mem_rd_en        = 1'b0;
		mem_rd_addr      = '0;
		mem_wr_en        = 1'b0;
		mem_wr_addr      = k_q;
		mem_wr_data      = new_entry;
		div_req.start    = 1'b0;
		div_req.dividend = {1'b0, prod_w, 1'b0}
			+ {{(plcm_pkg::DIVIDEND_W-plcm_pkg::OFF_W){1'b0}}, span_q};
		div_req.divisor  = {span_q, 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command == plcm_pkg::CMD_ADD) begin
						if (!full && empty) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = '0;
							mem_wr_data = req_entry;
						end else if (!full) begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = last_idx;
						end
					end else if (!empty) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = '0;
					end
				end
			end
			S_ADD_CMP: begin
				mem_wr_en = 1'b1;
				if (rd_gt_val) begin
					mem_wr_data = mem_rd_data;
					if (k_q != IW'(1)) begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = k_q - IW'(2);
					end
				end
			end
			S_ADD_PUT: begin
				mem_wr_en = 1'b1;
			end
			S_LK_FIRST: begin
				if (!val_le_rd) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = last_idx;
				end
			end
			S_LK_LAST: begin
				if (!val_ge_rd) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = IW'(1);
				end
			end
			S_LK_SCAN: begin
				if (!val_lt_rd) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = k_q + IW'(1);
				end
			end
			S_IP_MUL: begin
				div_req.start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: state, held operands and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the output word once taken, unless a new one replaces it
			if (out_valid_q && rsp.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q    <= req.value;
						cin_q    <= req_entry.color;
						color_q  <= '0;
						status_q <= plcm_pkg::ST_OK;
						k_q      <= cnt_q[IW-1:0];
						if (req.command == plcm_pkg::CMD_ADD) begin
							if (full) begin
								status_q <= plcm_pkg::ST_FULL;
								state_q  <= S_FINISH;
							end else if (empty) begin
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_FINISH;
							end else begin
								state_q <= S_ADD_CMP;
							end
						end else if (empty) begin
							status_q <= plcm_pkg::ST_EMPTY;
							state_q  <= S_FINISH;
						end else begin
							state_q <= S_LK_FIRST;
						end
					end
				end
				S_ADD_CMP: begin
					if (rd_gt_val) begin
						k_q <= k_q - IW'(1);
						if (k_q == IW'(1)) begin
							state_q <= S_ADD_PUT;
						end
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_FINISH;
					end
				end
				S_ADD_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_LK_FIRST: begin
					if (val_le_rd) begin
						color_q <= mem_rd_data.color;
						state_q <= S_FINISH;
					end else begin
						prev_q  <= mem_rd_data;
						state_q <= S_LK_LAST;
					end
				end
				S_LK_LAST: begin
					if (val_ge_rd) begin
						color_q <= mem_rd_data.color;
						state_q <= S_FINISH;
					end else begin
						k_q     <= IW'(1);
						state_q <= S_LK_SCAN;
					end
				end
				S_LK_SCAN: begin
					if (val_lt_rd) begin
						next_q  <= mem_rd_data;
						off_q   <= off_w[plcm_pkg::OFF_W-1:0];
						span_q  <= span_w[plcm_pkg::OFF_W-1:0];
						ch_q    <= '0;
						state_q <= S_IP_MUL;
					end else begin
						prev_q <= mem_rd_data;
						k_q    <= k_q + IW'(1);
					end
				end
				S_IP_MUL: begin
					neg_q   <= neg_w;
					state_q <= S_IP_DIV;
				end
				S_IP_DIV: begin
					if (div_rsp.done) begin
						color_q[ch_q] <= chan_res;
						if (ch_q == plcm_pkg::CHAN_IDX_W'(plcm_pkg::CHANNELS - 1)) begin
							state_q <= S_FINISH;
						end else begin
							ch_q    <= ch_q + plcm_pkg::CHAN_IDX_W'(1);
							state_q <= S_IP_MUL;
						end
					end
				end
				S_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_color_q  <= color_q;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	plcm_table #(
		.DEPTH (MAX_POINTS),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	plcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_req),
		.res    (div_rsp)
	);

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.red_out   = out_color_q[0];
	assign rsp.green_out = out_color_q[1];
	assign rsp.blue_out  = out_color_q[2];
	assign rsp.status    = out_status_q;

endmodule

[rtl/core/plcm_table.sv]
// Breakpoint memory: one write port and one read port with registered read data.
// Depends on plcm_pkg.
module plcm_table #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [IW-1:0]       rd_addr,
	output plcm_pkg::bp_entry_t rd_data,
	input  logic                wr_en,
	input  logic [IW-1:0]       wr_addr,
	input  plcm_pkg::bp_entry_t wr_data
);

	plcm_pkg::bp_entry_t mem [DEPTH];

	// Write one entry, read one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/plcm_div.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation rounding.
// Depends on plcm_pkg.
module plcm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  plcm_pkg::div_req_t ctl,
	output plcm_pkg::div_rsp_t res
);

	logic                            busy_q;
	logic                            done_q;
	logic [plcm_pkg::STEP_W-1:0]     step_q;
	logic [plcm_pkg::DIVIDEND_W-1:0] rem_q;
	logic [plcm_pkg::DIVIDEND_W-1:0] dsh_q;
	logic [plcm_pkg::QUOT_W-1:0]     quot_q;
	logic                            fits;

	assign fits = (rem_q >= dsh_q);

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= plcm_pkg::STEP_W'(plcm_pkg::QUOT_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - plcm_pkg::STEP_W'(1);
				end
			end
		end
	end

	// Subtract the shifted divisor where it fits, shift in one quotient bit
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= ctl.dividend;
			dsh_q  <= {2'b00, ctl.divisor, {(plcm_pkg::QUOT_W-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[plcm_pkg::QUOT_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule
